[sv/npim_pkg.sv]
// Package for the nearest palette index mapper.
// Holds widths, register codes, the bus carried along the cell row and the distance helper.
// No dependencies.
package npim_pkg;

  localparam int PALETTE_DEPTH_DEFAULT = 256;
  localparam int IDX_W      = 8;
  localparam int RGB_W      = 24;
  localparam int ARGB_W     = 32;
  localparam int SIZE_W     = 9;
  localparam int ALPHA_W    = 8;
  localparam int DIST_W     = 18;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THRESHOLD = 1'd1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [RGB_W-1:0]  RGB_MASK = 24'hFFFFFF;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic              valid;
    logic              is_write;
    logic [RGB_W-1:0]  data;
    logic [IDX_W-1:0]  idx;
    logic              fend;
    logic              transp;
    logic [DIST_W-1:0] best_d;
    logic [IDX_W-1:0]  best_i;
    logic [DIST_W-1:0] pend_d;
    logic [IDX_W-1:0]  pend_i;
    logic              pend_ok;
  } npim_bus_t;

  function automatic logic [15:0] chan_sq(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {8'd0, d} * {8'd0, d};
  endfunction

  function automatic logic [DIST_W-1:0] rgb_dist(input logic [RGB_W-1:0] a,
                                                  input logic [RGB_W-1:0] b);
    return DIST_W'(chan_sq(a[23:16], b[23:16])) + DIST_W'(chan_sq(a[15:8], b[15:8]))
         + DIST_W'(chan_sq(a[7:0], b[7:0]));
  endfunction

endpackage

[sv/npim_if.sv]
// Valid/ready channel interfaces for pixel and palette transactions and for results.
// Depends on npim_pkg.
interface npim_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [npim_pkg::ARGB_W-1:0] pixel_argb;
  logic [npim_pkg::IDX_W-1:0]  entry_index;
  logic [npim_pkg::RGB_W-1:0]  entry_rgb;
  logic                        frame_end;

  modport source (output valid, kind, pixel_argb, entry_index, entry_rgb, frame_end,
                  input ready);
  modport sink (input valid, kind, pixel_argb, entry_index, entry_rgb, frame_end,
                output ready);
endinterface

interface npim_out_if;
  logic                       valid;
  logic                       ready;
  logic [npim_pkg::IDX_W-1:0] color_index;
  logic                       last_of_frame;

  modport source (output valid, color_index, last_of_frame, input ready);
  modport sink (input valid, color_index, last_of_frame, output ready);
endinterface

[sv/npim_cell.sv]
// One cell of the palette row: holds one palette entry and folds the running best.
// Depends on npim_pkg.
module npim_cell #(
  parameter int CELL_IDX = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic [npim_pkg::SIZE_W-1:0] eff_size,
  input  npim_pkg::npim_bus_t         bus_i,
  output npim_pkg::npim_bus_t         bus_o
);
  import npim_pkg::*;

  logic [RGB_W-1:0] entry_r;
  npim_bus_t        bus_r;
  npim_bus_t        bus_nxt;
  logic             in_use;

  assign in_use = SIZE_W'(CELL_IDX) < eff_size;

  always_comb begin
    bus_nxt = bus_i;
    if (bus_i.pend_ok && (bus_i.pend_d < bus_i.best_d)) begin
      bus_nxt.best_d = bus_i.pend_d;
      bus_nxt.best_i = bus_i.pend_i;
    end
    bus_nxt.pend_d  = rgb_dist(bus_i.data, entry_r);
    bus_nxt.pend_i  = IDX_W'(CELL_IDX);
    bus_nxt.pend_ok = bus_i.valid && !bus_i.is_write && !bus_i.transp && in_use;
  end

  always_ff @(posedge clk) begin
    if (advance && bus_i.valid && bus_i.is_write && (bus_i.idx == IDX_W'(CELL_IDX))) begin
      entry_r <= bus_i.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.valid <= 1'b0;
    end else if (advance) begin
      bus_r <= bus_nxt;
    end
  end

  assign bus_o = bus_r;

endmodule

[sv/nearest_palette_index_mapper.sv]
// Nearest palette index mapper. Every transaction, pixel or palette write, enters a row of
// PALETTE_DEPTH-1 cells, one cell per palette slot from 1 up, and moves one cell per cycle while the
// row advances, so one transaction is accepted per cycle unless the row is stalled; a pixel's index
// is taken from the last cell into the output register. A stalled result halts the whole row.
// Palette writes travel the same row, so they affect exactly the pixels accepted after them.
// Depends on npim_pkg, npim_if and npim_cell.
module nearest_palette_index_mapper #(
  parameter int PALETTE_DEPTH = npim_pkg::PALETTE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  npim_in_if.sink                         in_if,
  npim_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [npim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [npim_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import npim_pkg::*;

  logic [SIZE_W-1:0]  palette_size_r;
  logic [ALPHA_W-1:0] alpha_threshold_r;
  logic [SIZE_W-1:0]  eff_size;
  logic               advance;
  npim_bus_t          bus [PALETTE_DEPTH];
  npim_bus_t          last_bus;
  logic [IDX_W-1:0]   final_idx;
  logic               out_valid_r;
  logic [IDX_W-1:0]   color_index_r;
  logic               last_of_frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_size_r    <= SIZE_W'(256);
      alpha_threshold_r <= ALPHA_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PALETTE_SIZE:    palette_size_r    <= cfg_wdata[SIZE_W-1:0];
        CFG_ALPHA_THRESHOLD: alpha_threshold_r <= cfg_wdata[ALPHA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (palette_size_r < SIZE_W'(2)) begin
      eff_size = SIZE_W'(2);
    end else if (palette_size_r > SIZE_W'(PALETTE_DEPTH)) begin
      eff_size = SIZE_W'(PALETTE_DEPTH);
    end else begin
      eff_size = palette_size_r;
    end
  end

  assign advance     = !out_valid_r || out_if.ready;
  assign in_if.ready = advance;

  always_comb begin
    bus[0].valid    = in_if.valid;
    bus[0].is_write = (in_if.kind == KIND_WRITE);
    bus[0].data     = (in_if.kind == KIND_WRITE) ? in_if.entry_rgb
                                                  : (in_if.pixel_argb[RGB_W-1:0] & RGB_MASK);
    bus[0].idx      = in_if.entry_index;
    bus[0].fend     = in_if.frame_end;
    bus[0].transp   = in_if.pixel_argb[ARGB_W-1:RGB_W] < alpha_threshold_r;
    bus[0].best_d   = DIST_MAX;
    bus[0].best_i   = IDX_W'(1);
    bus[0].pend_d   = DIST_MAX;
    bus[0].pend_i   = IDX_W'(1);
    bus[0].pend_ok  = 1'b0;
  end

  for (genvar k = 1; k < PALETTE_DEPTH; k++) begin : g_cell
    npim_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .eff_size (eff_size),
      .bus_i    (bus[k-1]),
      .bus_o    (bus[k])
    );
  end

  assign last_bus = bus[PALETTE_DEPTH-1];

  always_comb begin
    if (last_bus.transp) begin
      final_idx = '0;
    end else if (last_bus.pend_ok && (last_bus.pend_d < last_bus.best_d)) begin
      final_idx = last_bus.pend_i;
    end else begin
      final_idx = last_bus.best_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= last_bus.valid && !last_bus.is_write;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      color_index_r   <= final_idx;
      last_of_frame_r <= last_bus.fend;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.color_index   = color_index_r;
  assign out_if.last_of_frame = last_of_frame_r;

  a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (SIZE_W'(color_index_r) < eff_size))
    else $error("result index beyond the palette in use");

  a_accept_enters_row: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> bus[1].valid)
    else $error("accepted transaction did not enter the cell row");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule

[verif/nearest_palette_index_mapper_checker.sv]
`timescale 1ns / 1ps
// Result checker for nearest_palette_index_mapper: watches both channels and the register port,
// predicts each pixel's palette index and compares it with the result channel.
// Depends on npim_pkg and npim_if.
module nearest_palette_index_mapper_checker #(
  parameter int PALETTE_DEPTH = npim_pkg::PALETTE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  npim_in_if                              pix_ch,
  npim_out_if                             idx_ch,
  input  logic                            cfg_we,
  input  logic [npim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [npim_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatches,
  output int                              pending,
  output int                              compared
);
  import npim_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] color_index;
    logic             last_of_frame;
  } mapped_pixel_t;

  logic [RGB_W-1:0]   palette [PALETTE_DEPTH];
  logic [SIZE_W-1:0]  size_reg;
  logic [ALPHA_W-1:0] alpha_min;
  mapped_pixel_t      awaited [$];

  function automatic int unsigned color_gap(input logic [RGB_W-1:0] a,
                                            input logic [RGB_W-1:0] b);
    int unsigned sum;
    int          d;
    sum = 0;
    for (int c = 0; c < 3; c++) begin
      d = int'(a[8*c +: 8]) - int'(b[8*c +: 8]);
      sum += d * d;
    end
    return sum;
  endfunction

  function automatic logic [IDX_W-1:0] nearest_index(input logic [ARGB_W-1:0] argb);
    int unsigned      entries;
    int unsigned      gap;
    int unsigned      best_gap;
    logic [IDX_W-1:0] best;
    if (argb[31:24] < alpha_min) return '0;
    entries = size_reg;
    if (entries < 2) entries = 2;
    if (entries > PALETTE_DEPTH) entries = PALETTE_DEPTH;
    best = IDX_W'(1);
    best_gap = 32'hFFFF_FFFF;
    for (int p = 1; p < entries; p++) begin
      gap = color_gap(argb[RGB_W-1:0], palette[p]);
      if (gap < best_gap) begin
        best_gap = gap;
        best = IDX_W'(p);
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    mapped_pixel_t want;
    if (!rst_n) begin
      awaited.delete();
      size_reg = SIZE_W'(PALETTE_DEPTH_DEFAULT);
      alpha_min = ALPHA_W'(1);
      mismatches = 0;
      compared = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PALETTE_SIZE: begin
            size_reg = cfg_wdata[SIZE_W-1:0];
          end
          CFG_ALPHA_THRESHOLD: begin
            alpha_min = cfg_wdata[ALPHA_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (pix_ch.valid && pix_ch.ready) begin
        if (pix_ch.kind == KIND_WRITE) begin
          if (pix_ch.entry_index < PALETTE_DEPTH) palette[pix_ch.entry_index] = pix_ch.entry_rgb;
        end else begin
          want.color_index = nearest_index(pix_ch.pixel_argb);
          want.last_of_frame = pix_ch.frame_end;
          awaited = {awaited, want};
        end
      end
      if (idx_ch.valid && idx_ch.ready) begin
        compared++;
        if (awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with nothing expected: color_index %0d last_of_frame %0b",
                     $realtime, idx_ch.color_index, idx_ch.last_of_frame);
          end
        end else begin
          want = awaited.pop_front();
          if (want.color_index !== idx_ch.color_index ||
              want.last_of_frame !== idx_ch.last_of_frame) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: index expected %0d got %0d, frame end expected %0b got %0b",
                       $realtime, want.color_index, idx_ch.color_index,
                       want.last_of_frame, idx_ch.last_of_frame);
            end
          end
        end
      end
    end
    pending = awaited.size();
  end

endmodule

[verif/nearest_palette_index_mapper_tb.sv]
`timescale 1ns / 1ps
// Testbench top for nearest_palette_index_mapper: drives pixel and palette write transactions,
// register settings and result back-pressure, and reports the verdict from the checker.
// Depends on npim_pkg, npim_if, the mapper RTL and nearest_palette_index_mapper_checker.
module nearest_palette_index_mapper_tb;
  import npim_pkg::*;

  localparam int PALETTE_DEPTH  = PALETTE_DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES  = 2 * PALETTE_DEPTH + 16;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int PHASES         = 10;
  localparam int PRESSURE_PHASE = 3;
  localparam int PRESSURE_ITEMS = 400;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  npim_in_if  pix_ch ();
  npim_out_if idx_ch ();

  int mismatches;
  int pending;
  int compared;
  int cycles = 0;
  int hold_cycles = 0;
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;
  int pixels_sent = 0;
  int writes_sent = 0;
  int settings_used = 0;
  int cur_eff;
  logic [ALPHA_W-1:0] cur_alpha;
  logic [RGB_W-1:0]   pal_rgb [PALETTE_DEPTH];
  bit                 pal_set [PALETTE_DEPTH];

  nearest_palette_index_mapper #(.PALETTE_DEPTH(PALETTE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (pix_ch),
    .out_if    (idx_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nearest_palette_index_mapper_checker #(.PALETTE_DEPTH(PALETTE_DEPTH)) results_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_ch     (pix_ch),
    .idx_ch     (idx_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending),
    .compared   (compared)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("nearest_palette_index_mapper test failed");
      $finish;
    end
  end

  task automatic send(input logic kind, input logic [ARGB_W-1:0] argb,
                      input logic [IDX_W-1:0] slot, input logic [RGB_W-1:0] rgb,
                      input logic fend);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk);
      pix_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_ch.valid       <= 1'b1;
    pix_ch.kind        <= kind;
    pix_ch.pixel_argb  <= argb;
    pix_ch.entry_index <= slot;
    pix_ch.entry_rgb   <= rgb;
    pix_ch.frame_end   <= fend;
    do @(posedge clk); while (!pix_ch.ready);
    if (kind == KIND_WRITE) begin
      pal_rgb[slot] = rgb;
      pal_set[slot] = 1'b1;
      writes_sent++;
    end else begin
      pixels_sent++;
    end
  endtask

  task automatic wait_results();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= reg_index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic fill_palette(input int entries);
    for (int p = 1; p < entries; p++) begin
      if (!pal_set[p]) send(KIND_WRITE, $urandom, IDX_W'(p), RGB_W'($urandom), 1'($urandom));
    end
  endtask

  // Palette writes leave no result behind, so the row is given time to empty before a change.
  task automatic apply_setting(input logic [SIZE_W-1:0] size, input logic [ALPHA_W-1:0] alpha);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_PALETTE_SIZE, CFG_DATA_W'(size));
    write_reg(CFG_ALPHA_THRESHOLD, CFG_DATA_W'(alpha));
    cur_alpha = alpha;
    cur_eff = (size < 2) ? 2 : (size > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(size);
    settings_used++;
    fill_palette(cur_eff);
  endtask

  initial begin
    int               wait_n;
    idx_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_cycles > 0) begin
        @(negedge clk);
        idx_ch.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      wait_n = sink_steady ? 0 : $urandom_range(0, 11);
      if (wait_n > 0) begin
        @(negedge clk);
        idx_ch.ready <= 1'b0;
        repeat (wait_n - 1) @(negedge clk);
      end
      @(negedge clk);
      idx_ch.ready <= 1'b1;
      do @(posedge clk); while (!idx_ch.valid);
    end
  end

  initial begin
    logic [SIZE_W-1:0]  size_plan [PHASES];
    logic [ALPHA_W-1:0] alpha_plan [PHASES];
    logic [ALPHA_W-1:0] alpha;
    logic [RGB_W-1:0]   rgb;
    int                 burst;
    int                 pick;

    pix_ch.valid       = 1'b0;
    pix_ch.kind        = KIND_PIXEL;
    pix_ch.pixel_argb  = '0;
    pix_ch.entry_index = '0;
    pix_ch.entry_rgb   = '0;
    pix_ch.frame_end   = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_PALETTE_SIZE;
    cfg_wdata          = '0;
    for (int p = 0; p < PALETTE_DEPTH; p++) begin
      pal_set[p] = 1'b0;
      pal_rgb[p] = '0;
    end
    size_plan  = '{9'd3, 9'd17, 9'd511, 9'd2, 9'd256, 9'd1, 9'd64, 9'd300, 9'd0, 9'd0};
    alpha_plan = '{8'd1, 8'd255, 8'd0, 8'd128, 8'd0, 8'd1, 8'd0, 8'd200, 8'd255, 8'd0};
    size_plan[9]  = SIZE_W'($urandom_range(2, PALETTE_DEPTH));
    alpha_plan[4] = ALPHA_W'($urandom_range(0, 255));
    alpha_plan[9] = ALPHA_W'($urandom_range(0, 255));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Palette size 4: slots 1 to 3 searched; slot 0 holds white but must never be chosen.
    apply_setting(9'd4, 8'h80);
    send(KIND_WRITE, 32'h0, 8'd0, 24'hFFFFFF, 1'b0);
    send(KIND_WRITE, 32'h0, 8'd1, 24'h000000, 1'b0);
    send(KIND_WRITE, 32'h0, 8'd2, 24'hFFFFFF, 1'b0);
    send(KIND_WRITE, 32'h0, 8'd3, 24'h020000, 1'b1);
    send(KIND_PIXEL, 32'h7FFFFFFF, 8'hFF, 24'hFFFFFF, 1'b0);
    send(KIND_PIXEL, 32'h80FFFFFF, 8'h00, 24'h000000, 1'b0);
    send(KIND_PIXEL, 32'hFF000000, 8'h00, 24'h000000, 1'b0);
    send(KIND_PIXEL, 32'hFF010000, 8'h00, 24'h000000, 1'b0);
    send(KIND_PIXEL, 32'h00FFFFFF, 8'h00, 24'h000000, 1'b1);
    send(KIND_PIXEL, 32'hFF030000, 8'h00, 24'h000000, 1'b0);
    send(KIND_PIXEL, 32'h80808080, 8'h00, 24'h000000, 1'b0);
    send(KIND_PIXEL, 32'hFFFFFFFF, 8'h00, 24'h000000, 1'b1);
    apply_setting(9'd0, 8'd0);
    send(KIND_PIXEL, 32'h00123456, 8'h00, 24'h000000, 1'b0);
    send(KIND_PIXEL, 32'hFFFFFFFF, 8'h00, 24'h000000, 1'b1);
    apply_setting(9'd1, 8'd255);
    send(KIND_PIXEL, 32'hFEFFFFFF, 8'h00, 24'h000000, 1'b0);
    send(KIND_PIXEL, 32'hFF7F7F7F, 8'h00, 24'h000000, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      apply_setting(size_plan[ph], alpha_plan[ph]);
      src_steady  = (ph == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0) && (ph != PRESSURE_PHASE);
      burst = (ph == PRESSURE_PHASE) ? PRESSURE_ITEMS
                                     : (RANDOM_ITEMS - PRESSURE_ITEMS) / (PHASES - 1);
      if (ph == PRESSURE_PHASE) hold_cycles = 800;
      for (int n = 0; n < burst; n++) begin
        if (n == burst / 2 && ph != PRESSURE_PHASE) wait_results();
        if ($urandom_range(0, 99) < 18) begin
          rgb = ($urandom_range(0, 3) == 0) ? pal_rgb[$urandom_range(1, cur_eff - 1)]
                                            : RGB_W'($urandom);
          send(KIND_WRITE, $urandom, IDX_W'($urandom), rgb, 1'($urandom));
        end else begin
          pick = $urandom_range(0, 9);
          case (pick)
            0: alpha = 8'h00;
            1: alpha = 8'hFF;
            2: alpha = cur_alpha;
            3: alpha = cur_alpha - 8'd1;
            default: alpha = ALPHA_W'($urandom);
          endcase
          rgb = pal_rgb[$urandom_range(1, cur_eff - 1)];
          pick = $urandom_range(0, 9);
          if (pick >= 7) rgb = RGB_W'($urandom);
          else if (pick >= 4) rgb = rgb ^ (RGB_W'($urandom) & 24'h070707);
          send(KIND_PIXEL, {alpha, rgb}, IDX_W'($urandom), RGB_W'($urandom),
               $urandom_range(0, 7) == 0);
        end
      end
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d pixel and %0d palette write transactions under %0d register settings.",
             pixels_sent, writes_sent, settings_used);
    $display("Compared %0d results over sizes 0 to 511, thresholds 0 to 255 and a long stall.",
             compared);
    if (mismatches == 0 && pending == 0) begin
      $display("nearest_palette_index_mapper test passed");
    end else begin
      $display("nearest_palette_index_mapper test failed");
    end
    $finish;
  end

endmodule

[nearest_palette_index_mapper.f]
sv/npim_pkg.sv
sv/npim_if.sv
sv/npim_cell.sv
sv/nearest_palette_index_mapper.sv
verif/nearest_palette_index_mapper_checker.sv
verif/nearest_palette_index_mapper_tb.sv
